// ===== design/aest_pkg.sv =====
// Shared types and constants of the animated effect slot table.
package aest_pkg;

    localparam int FINE_W  = 20;
    localparam int SPEED_W = 12;
    localparam int PHASE_W = 16;
    localparam int TILE_W  = 10;
    localparam int STEP_W  = 8;
    localparam int SIZE_W  = 2;
    localparam int LEN_W   = 8;
    localparam int POS_W   = 14;
    localparam int SCROLL_W = 12;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 48;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_DRAW  = 2'd2;

    localparam logic KIND_SPRITE = 1'b0;
    localparam logic KIND_END    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_WR,
        S_DRAW_RD,
        S_DRAW_EV,
        S_DRAW_END
    } t_state;

    typedef struct packed {
        logic [FINE_W-1:0]  fine_x;
        logic [FINE_W-1:0]  fine_y;
        logic [SPEED_W-1:0] speed_x;
        logic [SPEED_W-1:0] speed_y;
        logic [PHASE_W-1:0] phase;
        logic [TILE_W-1:0]  base_tile;
        logic [STEP_W-1:0]  step_rate;
        logic [SIZE_W-1:0]  size_shift;
        logic [LEN_W-1:0]   length_frames;
        logic               big_flag;
    } t_slot;

    typedef struct packed {
        t_slot slot;
        logic  die;
    } t_tick;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [TILE_W-1:0] tile;
        logic [SIZE_W-1:0] size;
        logic              affine;
        logic              visible;
    } t_sprite;

endpackage

// ===== design/animated_effect_slot_table.sv =====
// Top level of the animated effect slot table: slot memory, sequencer and output beat.
// Start: the slot is written in the cycle the beat is accepted.
// Tick: each live slot is read, then written back; dead slots are skipped.
// Draw: each live slot is read, then evaluated, then the closing beat; a stalled output holds the sweep.
// Throughput is set by the single-port read-modify-write of the slot memory.
// Reset (i_rst_n low, synchronous) kills all slots, zeroes the pointer and scroll speed.
module animated_effect_slot_table
    import aest_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [SCROLL_W-1:0]   i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // start_x, start_y, vel_x, vel_y, tile_base, anim_step, size_log,
    // anim_length, doubled, start_phase, zero fill
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // req_type
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // sprite_x, sprite_y, tile_index, size_code, affine_on, zero fill
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // item_kind
    output logic                  o_m_tuser,
    output logic                  o_m_tlast
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

    t_state r_state, n_state;
    logic [SLOT_COUNT-1:0] r_live, n_live;
    logic [IW-1:0] r_alloc, n_alloc, r_idx, n_idx, alloc_next, wr_addr;
    logic [SCROLL_W-1:0] r_scroll;
    logic r_out_valid, n_out_valid;
    t_sprite r_out, n_out;
    logic r_out_kind, n_out_kind;
    logic r_out_last, n_out_last;
    logic load_out;

    t_slot r_mem [SLOT_COUNT];
    t_slot r_rd_data, wr_data, start_rec;
    logic rd_en, we;

    t_tick   tick_res;
    t_sprite sprite_res;

    logic accept, out_free, idx_last;

    aest_slot_math u_math (
        .i_slot   (r_rd_data),
        .i_scroll (r_scroll),
        .o_tick   (tick_res),
        .o_sprite (sprite_res)
    );

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        start_rec.fine_x = {{3{i_s_tdata[9]}}, i_s_tdata[9:0], 7'b0};
        start_rec.fine_y = {{3{i_s_tdata[19]}}, i_s_tdata[19:10], 7'b0};
        start_rec.speed_x = i_s_tdata[31:20];
        start_rec.speed_y = i_s_tdata[43:32];
        start_rec.base_tile = i_s_tdata[53:44];
        start_rec.step_rate = i_s_tdata[61:54];
        start_rec.size_shift = i_s_tdata[63:62];
        start_rec.length_frames = i_s_tdata[71:64];
        start_rec.big_flag = i_s_tdata[72];
        start_rec.phase = {{5{i_s_tdata[83]}}, i_s_tdata[83:73]};
    end

    assign alloc_next = (r_alloc == LAST_IDX) ? '0 : r_alloc + IW'(1);
    assign idx_last   = (r_idx == LAST_IDX);
    assign out_free   = ~r_out_valid | i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid & o_s_tready;

    always_comb begin
        n_state = r_state;
        n_live = r_live;
        n_alloc = r_alloc;
        n_idx = r_idx;
        rd_en = 1'b0;
        we = 1'b0;
        wr_addr = r_idx;
        wr_data = tick_res.slot;
        load_out = 1'b0;
        n_out = sprite_res;
        n_out_kind = KIND_SPRITE;
        n_out_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_s_tuser)
                        REQ_START: begin
                            n_alloc = alloc_next;
                            we = 1'b1;
                            wr_addr = alloc_next;
                            wr_data = start_rec;
                            n_live[alloc_next] = 1'b1;
                        end
                        REQ_TICK: begin
                            n_idx = '0;
                            n_state = S_TICK_RD;
                        end
                        REQ_DRAW: begin
                            n_idx = '0;
                            n_state = S_DRAW_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK_RD: begin
                if (r_live[r_idx]) begin
                    rd_en = 1'b1;
                    n_state = S_TICK_WR;
                end else if (idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_TICK_WR: begin
                we = 1'b1;
                if (tick_res.die) begin
                    n_live[r_idx] = 1'b0;
                end
                n_state = idx_last ? S_IDLE : S_TICK_RD;
                if (!idx_last) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_DRAW_RD: begin
                if (r_live[r_idx]) begin
                    rd_en = 1'b1;
                    n_state = S_DRAW_EV;
                end else if (idx_last) begin
                    n_state = S_DRAW_END;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_DRAW_EV: begin
                if (!sprite_res.visible || out_free) begin
                    load_out = sprite_res.visible;
                    n_state = idx_last ? S_DRAW_END : S_DRAW_RD;
                    if (!idx_last) begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_DRAW_END: begin
                n_out = '0;
                n_out_kind = KIND_END;
                n_out_last = 1'b1;
                if (out_free) begin
                    load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = load_out | (r_out_valid & ~i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live <= '0;
            r_alloc <= '0;
            r_idx <= '0;
            r_scroll <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live <= n_live;
            r_alloc <= n_alloc;
            r_idx <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_scroll <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
            r_out_kind <= n_out_kind;
            r_out_last <= n_out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out.affine, r_out.size, r_out.tile, r_out.pos_y, r_out.pos_x};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== design/aest_slot_math.sv =====
// Per-slot arithmetic: tick update of one record and its sprite fields.
module aest_slot_math
    import aest_pkg::*;
(
    input  t_slot                i_slot,
    input  logic [SCROLL_W-1:0]  i_scroll,
    output t_tick                o_tick,
    output t_sprite              o_sprite
);

    logic [PHASE_W-1:0] phase_n;
    logic [6:0]         half_w;
    logic [TILE_W-1:0]  frame_sh;

    always_comb begin
        phase_n = i_slot.phase + {{(PHASE_W-STEP_W){1'b0}}, i_slot.step_rate};

        o_tick.slot = i_slot;
        o_tick.slot.phase = phase_n;
        o_tick.slot.fine_x = i_slot.fine_x
            + {{(FINE_W-SPEED_W){i_slot.speed_x[SPEED_W-1]}}, i_slot.speed_x};
        o_tick.slot.fine_y = i_slot.fine_y
            + {{(FINE_W-SPEED_W){i_slot.speed_y[SPEED_W-1]}}, i_slot.speed_y}
            + {{(FINE_W-SCROLL_W){i_scroll[SCROLL_W-1]}}, i_scroll};
        o_tick.die = $signed(phase_n[PHASE_W-1:4])
                     >= $signed({4'b0000, i_slot.length_frames});

        half_w = (i_slot.big_flag ? 7'd8 : 7'd4) << i_slot.size_shift;
        frame_sh = i_slot.phase[13:4] << i_slot.size_shift;
        o_sprite.pos_x = {i_slot.fine_x[FINE_W-1], i_slot.fine_x[FINE_W-1:7]}
                         - {7'b0, half_w};
        o_sprite.pos_y = {i_slot.fine_y[FINE_W-1], i_slot.fine_y[FINE_W-1:7]}
                         - {7'b0, half_w};
        o_sprite.tile    = i_slot.base_tile + frame_sh;
        o_sprite.size    = i_slot.size_shift;
        o_sprite.affine  = i_slot.big_flag;
        o_sprite.visible = ~i_slot.phase[PHASE_W-1];
    end

endmodule

// ===== design/aest_checker.sv =====
// Port-level checks of the animated effect slot table and their bind.
module aest_checker
    import aest_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [1:0]            i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tuser,
    input logic                  o_m_tlast
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output beat valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("stalled output beat changed");

    a_end_beat_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == o_m_tuser)
                       && (!o_m_tlast || o_m_tdata == '0))
        else $error("closing beat malformed");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == REQ_TICK || i_s_tuser == REQ_DRAW)
        |=> !o_s_tready)
        else $error("input accepted during slot sweep");

endmodule

bind animated_effect_slot_table aest_checker u_aest_checker (.*);

// ===== bench/animated_effect_slot_table_tb.sv =====
// Self-checking bench for the animated effect slot table: directed and random start/tick/draw streams.
`timescale 1ns / 1ps

module animated_effect_slot_table_tb;
    import aest_pkg::*;

    localparam int          SLOTS        = 32;
    localparam int          SETTLE_TICKS = 80;
    localparam logic [1:0]  REQ_NONE     = 2'd3;

    typedef struct {
        logic [1:0]  req;
        logic [9:0]  sx;
        logic [9:0]  sy;
        logic [11:0] vx;
        logic [11:0] vy;
        logic [9:0]  tile;
        logic [7:0]  step;
        logic [1:0]  size;
        logic [7:0]  len;
        logic        dbl;
        logic [10:0] ph;
    } t_effect_req;

    typedef struct {
        logic        kind;
        logic [13:0] px;
        logic [13:0] py;
        logic [9:0]  tile;
        logic [1:0]  size;
        logic        affine;
        logic        last;
    } t_sprite_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [SCROLL_W-1:0]   i_cfg_wdata = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic [1:0]            i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    animated_effect_slot_table #(.SLOT_COUNT(SLOTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the slot table
    bit                 live [SLOTS];
    logic [FINE_W-1:0]  pos_x [SLOTS];
    logic [FINE_W-1:0]  pos_y [SLOTS];
    logic [11:0]        vel_x [SLOTS];
    logic [11:0]        vel_y [SLOTS];
    logic [15:0]        phase [SLOTS];
    logic [9:0]         tile0 [SLOTS];
    logic [7:0]         rate [SLOTS];
    logic [1:0]         shift [SLOTS];
    logic [7:0]         frames [SLOTS];
    logic               big [SLOTS];
    logic [4:0]         ring_ptr = '0;
    logic [11:0]        scroll = '0;

    t_effect_req  request_q [$];
    t_sprite_beat draw_list_q [$];
    t_effect_req  held_req;
    bit           beat_held = 0;
    bit           idling_on = 1;
    int           src_gap = 0;
    int           sink_gap = 0;
    int           err_count = 0;
    int           n_start = 0, n_tick = 0, n_draw = 0, n_none = 0;
    int           n_sprite = 0, n_end = 0;

    function automatic logic [IN_DATA_W-1:0] pack_req(t_effect_req r);
        return {4'b0, r.ph, r.dbl, r.len, r.size, r.step, r.tile, r.vy, r.vx, r.sy, r.sx};
    endfunction

    task automatic apply_request(t_effect_req r);
        t_sprite_beat b;
        int           w;
        int           fr;
        logic [4:0]   s;
        case (r.req)
            REQ_START: begin
                n_start++;
                s = (ring_ptr == SLOTS - 1) ? 5'd0 : ring_ptr + 5'd1;
                ring_ptr = s;
                pos_x[s]  = {{3{r.sx[9]}}, r.sx, 7'b0};
                pos_y[s]  = {{3{r.sy[9]}}, r.sy, 7'b0};
                vel_x[s]  = r.vx;
                vel_y[s]  = r.vy;
                tile0[s]  = r.tile;
                rate[s]   = r.step;
                shift[s]  = r.size;
                frames[s] = r.len;
                big[s]    = r.dbl;
                phase[s]  = {{5{r.ph[10]}}, r.ph};
                live[s]   = 1;
            end
            REQ_TICK: begin
                n_tick++;
                for (int i = 0; i < SLOTS; i++) begin
                    if (live[i]) begin
                        phase[i] = phase[i] + {8'b0, rate[i]};
                        fr = $signed(phase[i]) >>> 4;
                        if (fr >= int'(frames[i]))
                            live[i] = 0;
                        pos_x[i] = pos_x[i] + {{8{vel_x[i][11]}}, vel_x[i]};
                        pos_y[i] = pos_y[i] + {{8{vel_y[i][11]}}, vel_y[i]}
                                   + {{8{scroll[11]}}, scroll};
                    end
                end
            end
            REQ_DRAW: begin
                n_draw++;
                for (int i = 0; i < SLOTS; i++) begin
                    if (live[i] && !phase[i][15]) begin
                        w = (big[i] ? 8 : 4) << shift[i];
                        b.kind   = KIND_SPRITE;
                        b.px     = 14'(int'($signed(pos_x[i][19:7])) - w);
                        b.py     = 14'(int'($signed(pos_y[i][19:7])) - w);
                        b.tile   = 10'(tile0[i] + (phase[i][15:4] << shift[i]));
                        b.size   = shift[i];
                        b.affine = big[i];
                        b.last   = 1'b0;
                        draw_list_q.push_back(b);
                    end
                end
                b = '{KIND_END, 14'd0, 14'd0, 10'd0, 2'd0, 1'b0, 1'b1};
                draw_list_q.push_back(b);
            end
            default: n_none++;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            beat_held = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                apply_request(held_req);
                beat_held = 0;
            end
            if (!beat_held) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    held_req = request_q.pop_front();
                    beat_held = 1;
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= pack_req(held_req);
                    i_s_tuser <= held_req.req;
                    if (idling_on && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 17);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            err_count++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_sprite_beat e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (draw_list_q.size() == 0) begin
                    err_count++;
                    $display("%0t mismatch: expected no beat actual tdata %0h last %0b",
                             $time, o_m_tdata, o_m_tlast);
                end else begin
                    e = draw_list_q.pop_front();
                    if (e.kind == KIND_END) n_end++;
                    else n_sprite++;
                    check_field("item_kind", e.kind, o_m_tuser);
                    check_field("sprite_x", e.px, o_m_tdata[13:0]);
                    check_field("sprite_y", e.py, o_m_tdata[27:14]);
                    check_field("tile_index", e.tile, o_m_tdata[37:28]);
                    check_field("size_code", e.size, o_m_tdata[39:38]);
                    check_field("affine_on", e.affine, o_m_tdata[40]);
                    check_field("last", e.last, o_m_tlast);
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (idling_on && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 17);
            end
        end
    end

    function automatic t_effect_req any_req(logic [1:0] req);
        t_effect_req r;
        r.req  = req;
        r.sx   = 10'($urandom);
        r.sy   = 10'($urandom);
        r.vx   = 12'($urandom);
        r.vy   = 12'($urandom);
        r.tile = 10'($urandom);
        r.step = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31)) : 8'($urandom);
        r.size = 2'($urandom);
        r.len  = 8'($urandom);
        r.dbl  = 1'($urandom);
        r.ph   = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 200));
        return r;
    endfunction

    function automatic t_effect_req fixed_start(logic [9:0] sx, logic [9:0] sy,
                                                 logic [11:0] vx, logic [11:0] vy,
                                                 logic [9:0] tile, logic [7:0] step,
                                                 logic [1:0] size, logic [7:0] len,
                                                 logic dbl, logic [10:0] ph);
        t_effect_req r;
        r = '{REQ_START, sx, sy, vx, vy, tile, step, size, len, dbl, ph};
        return r;
    endfunction

    task automatic wait_idle();
        while (request_q.size() != 0 || beat_held || draw_list_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_scroll(logic [11:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scroll = v;
    endtask

    task automatic queue_random_run(int count);
        int k;
        k = 0;
        while (k < count) begin
            if ($urandom_range(0, 9) == 0) begin
                request_q.push_back(any_req(2'($urandom)));
                k++;
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    request_q.push_back(any_req(REQ_START));
                    k++;
                end
                repeat ($urandom_range(0, 5)) begin
                    request_q.push_back(any_req(REQ_TICK));
                    k++;
                end
                request_q.push_back(any_req(REQ_DRAW));
                k++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_scroll(12'd0);
        request_q.push_back(any_req(REQ_DRAW));
        request_q.push_back(any_req(REQ_NONE));
        request_q.push_back(fixed_start(10'h1FF, 10'h1FF, 12'h7FF, 12'h7FF, 10'h3FF,
                                        8'd0, 2'd3, 8'd255, 1'b1, 11'h3FF));
        request_q.push_back(fixed_start(10'h200, 10'h200, 12'h800, 12'h800, 10'h000,
                                        8'd255, 2'd0, 8'd0, 1'b0, 11'h000));
        request_q.push_back(fixed_start(10'h000, 10'h3FF, 12'h001, 12'hFFF, 10'h155,
                                        8'd255, 2'd1, 8'd1, 1'b0, 11'h400));
        request_q.push_back(fixed_start(10'h155, 10'h2AA, 12'h555, 12'hAAA, 10'h2AA,
                                        8'd1, 2'd2, 8'd2, 1'b1, 11'h7FF));
        request_q.push_back(any_req(REQ_DRAW));
        request_q.push_back(any_req(REQ_TICK));
        request_q.push_back(any_req(REQ_DRAW));
        request_q.push_back(any_req(REQ_NONE));
        request_q.push_back(any_req(REQ_TICK));
        request_q.push_back(any_req(REQ_DRAW));
        request_q.push_back(any_req(REQ_TICK));
        request_q.push_back(any_req(REQ_TICK));
        request_q.push_back(any_req(REQ_DRAW));
        wait_idle();

        write_scroll(12'h7FF);
        queue_random_run(20);
        wait_idle();

        write_scroll(12'h800);
        queue_random_run(20);
        wait_idle();

        write_scroll(12'h7FF);
        request_q.push_back(fixed_start(10'h1FF, 10'h1FF, 12'h7FF, 12'h7FF, 10'h3F0,
                                        8'd0, 2'd0, 8'd255, 1'b0, 11'h000));
        for (int i = 0; i < 36; i++) begin
            request_q.push_back(any_req(REQ_TICK));
            if (i % 12 == 11)
                request_q.push_back(any_req(REQ_DRAW));
        end
        request_q.push_back(any_req(REQ_DRAW));
        wait_idle();

        write_scroll(12'($urandom));
        queue_random_run(8);
        wait_idle();

        idling_on = 0;
        write_scroll(12'hFFF);
        queue_random_run(8);
        wait_idle();

        $display("covered %0d starts, %0d ticks, %0d draws, %0d ignored requests",
                 n_start, n_tick, n_draw, n_none);
        $display("checked %0d sprite beats and %0d list ends over six scroll settings",
                 n_sprite, n_end);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d beats still expected", draw_list_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
design/aest_pkg.sv
design/aest_slot_math.sv
design/animated_effect_slot_table.sv
design/aest_checker.sv
bench/animated_effect_slot_table_tb.sv
